@@ rtl/core/drl_pkg.sv @@
// ----------------------------------------------------------------------------
// drl_pkg
// shared types, codes and channel arithmetic for the dither removal filter
// ----------------------------------------------------------------------------
`default_nettype none

package drl_pkg;

  // channel order inside a pixel: blue, green, red
  localparam int unsigned CHANNELS = 3;
  localparam int unsigned BLUE_CH  = 0;
  localparam int unsigned GREEN_CH = 1;
  localparam int unsigned RED_CH   = 2;

  localparam logic [8:0] LIFT_STEP = 9'd4;
  localparam logic [7:0] CHAN_MAX  = 8'd255;

  typedef logic [CHANNELS-1:0][7:0] rgb_t;

  typedef enum logic [1:0] {
    KIND_PASS   = 2'd0,
    KIND_FILTER = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef enum logic {
    MODE_4X1 = 1'b0,
    MODE_2X2 = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    REG_FILTER_MODE  = 2'd0,
    REG_RB_THRESHOLD = 2'd1,
    REG_G_THRESHOLD  = 2'd2
  } reg_index_t;

  typedef struct packed {
    mode_t      filter_mode;
    logic [7:0] red_blue_threshold;
    logic [7:0] green_threshold;
  } cfg_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [15:0] below_pixel;
    logic        even_row;
    logic        line_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       out_last;
  } out_item_t;

  // one queued request from front to back
  typedef struct packed {
    kind_t kind;
    rgb_t  b;
    rgb_t  p1;
    rgb_t  u;
    rgb_t  q;
    rgb_t  bx0;
    rgb_t  bx1;
  } work_t;

  function automatic logic [7:0] blend(input logic [7:0] g, input logic [7:0] h,
                                       input logic [7:0] t);
    logic signed [9:0]  d;
    logic signed [9:0]  ts;
    logic signed [10:0] s;
    d  = $signed({2'b00, h}) - $signed({2'b00, g});
    ts = $signed({2'b00, t});
    if (d >= ts) begin
      return g;
    end
    if (d < -ts) begin
      d = -ts;
    end
    s = $signed({2'b00, g, 1'b0}) + $signed({d[9], d});
    return s[8:1];
  endfunction

  function automatic logic [7:0] box(input logic [7:0] g, input logic [7:0] h,
                                     input logic [7:0] t);
    logic [8:0] d;
    d = {1'b0, h} - {1'b0, g};
    if ((h > g) && (d <= {1'b0, t})) begin
      return h;
    end
    return g;
  endfunction

  function automatic logic [7:0] chan_thr(input cfg_t cfg, input int unsigned ch);
    return (ch == GREEN_CH) ? cfg.green_threshold : cfg.red_blue_threshold;
  endfunction

  function automatic rgb_t expand(input logic [15:0] p);
    rgb_t v;
    v[BLUE_CH]  = {p[4:0], 3'b000};
    v[GREEN_CH] = {p[10:5], 2'b00};
    v[RED_CH]   = {p[15:11], 3'b000};
    return v;
  endfunction

  // even rows raise red and blue, saturating
  function automatic rgb_t lift(input rgb_t u, input logic even);
    rgb_t       v;
    logic [8:0] s;
    v = u;
    for (int unsigned ch = 0; ch < CHANNELS; ch++) begin
      s = {1'b0, u[ch]} + LIFT_STEP;
      if (even && (ch != GREEN_CH)) begin
        v[ch] = s[8] ? CHAN_MAX : s[7:0];
      end
    end
    return v;
  endfunction

  function automatic rgb_t blend_rgb(input rgb_t g, input rgb_t h, input cfg_t cfg);
    rgb_t v;
    for (int unsigned ch = 0; ch < CHANNELS; ch++) begin
      v[ch] = blend(g[ch], h[ch], chan_thr(cfg, ch));
    end
    return v;
  endfunction

  function automatic rgb_t box_rgb(input rgb_t g, input rgb_t h, input cfg_t cfg);
    rgb_t v;
    for (int unsigned ch = 0; ch < CHANNELS; ch++) begin
      v[ch] = box(g[ch], h[ch], chan_thr(cfg, ch));
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dither_removal_line_filter_unit.sv @@
// ----------------------------------------------------------------------------
// dither_removal_line_filter_unit
// 4x1 / 2x2 dither removal filter over an RGB565 scanline stream
// ----------------------------------------------------------------------------
//
//   channel   ports                          moves
//   --------  -----------------------------  ------------------------------
//   input     push, full, in_item            one pixel plus the pixel below
//   result    empty, pop, out_item           one filtered 8-8-8 pixel
//   config    wr_en, wr_index, wr_data       one register write, no wait
//
// one pixel request is taken per clock while the work queue has room
// a result passes the work queue and the back stage register before it is
// queued; the last pixel of a longer line yields two results, so the back
// stage holds it until both are out; its rate is set by that single back stage
// synchronous reset clears the config registers and the line window flag and empties both queues
// either side may stall on its own; the work queue soaks up the difference
// ----------------------------------------------------------------------------
`default_nettype none

module dither_removal_line_filter_unit #(
  parameter int unsigned WORK_DEPTH   = 4,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // pixel requests
  input  wire logic               push,
  output logic                    full,
  input  wire drl_pkg::in_item_t  in_item,
  // filtered results
  output logic                    empty,
  input  wire logic               pop,
  output drl_pkg::out_item_t      out_item,
  // configuration writes
  input  wire logic               wr_en,
  input  wire logic [1:0]         wr_index,
  input  wire logic [7:0]         wr_data
);

  drl_pkg::cfg_t      cfg;
  logic               accept;
  logic               work_push;
  drl_pkg::work_t     work_in;
  drl_pkg::work_t     work_head;
  logic               work_full;
  logic               work_empty;
  logic               work_pop;
  logic               res_push;
  logic               res_full;
  drl_pkg::out_item_t res;

  // configuration registers, the user writes them only while no request is in flight; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode        <= drl_pkg::MODE_4X1;
      cfg.red_blue_threshold <= '0;
      cfg.green_threshold    <= '0;
    end else if (wr_en) begin
      unique case (drl_pkg::reg_index_t'(wr_index))
        drl_pkg::REG_FILTER_MODE:  cfg.filter_mode <= drl_pkg::mode_t'(wr_data[0]);
        drl_pkg::REG_RB_THRESHOLD: cfg.red_blue_threshold <= wr_data;
        drl_pkg::REG_G_THRESHOLD:  cfg.green_threshold <= wr_data;
        default: ;
      endcase
    end
  end

  // a pixel is taken whenever the work queue has room, even if it
  // only primes the window
  assign full   = work_full;
  assign accept = push && !work_full;

  // front: expand, lift, window and first passes
  drl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .item      (in_item),
    .work_push (work_push),
    .work      (work_in)
  );

  // work queue between front and back
  drl_fifo #(
    .WIDTH ($bits(drl_pkg::work_t)),
    .DEPTH (WORK_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (work_push),
    .wdata (work_in),
    .full  (work_full),
    .pop   (work_pop),
    .rdata (work_head),
    .empty (work_empty)
  );

  // back: last passes and result sequencing
  drl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .work_empty (work_empty),
    .work       (work_head),
    .work_pop   (work_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  // result queue toward the consumer
  drl_fifo #(
    .WIDTH ($bits(drl_pkg::out_item_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );

  // the front never queues work that the queue cannot hold
  a_work_no_overflow: assert property (@(posedge clk) disable iff (rst)
    work_push |-> !work_full)
    else $error("work request queued while work queue full");

  // the back never emits into a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result emitted while result queue full");

  // back stage drains the work queue only when it has work to take
  a_pop_needs_work: assert property (@(posedge clk) disable iff (rst)
    work_pop |-> !work_empty)
    else $error("work queue popped while empty");

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not idle after reset");

endmodule

`default_nettype wire

@@ rtl/core/drl_fifo.sv @@
// ----------------------------------------------------------------------------
// drl_fifo
// small register queue, first word visible at the head
// ----------------------------------------------------------------------------
`default_nettype none

module drl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/drl_front.sv @@
// ----------------------------------------------------------------------------
// drl_front
// expands and lifts each pixel, keeps the line window, runs the first passes
// and queues one request per pixel that yields results
// ----------------------------------------------------------------------------
`default_nettype none

module drl_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire drl_pkg::cfg_t    cfg,
  input  wire logic             accept,
  input  wire drl_pkg::in_item_t item,
  output logic                  work_push,
  output drl_pkg::work_t        work
);

  logic          have_pending;
  drl_pkg::rgb_t lifted_window;
  drl_pkg::rgb_t pass0;
  drl_pkg::rgb_t pass1;
  drl_pkg::rgb_t box_cur;
  drl_pkg::rgb_t box_below;

  drl_pkg::rgb_t u;
  drl_pkg::rgb_t q;
  drl_pkg::rgb_t l;
  drl_pkg::rgb_t a;
  drl_pkg::rgb_t b;

  always_comb begin
    u = drl_pkg::expand(item.pixel);
    q = drl_pkg::expand(item.below_pixel);
    l = drl_pkg::lift(u, item.even_row);
    a = drl_pkg::blend_rgb(l, lifted_window, cfg);
    b = drl_pkg::blend_rgb(l, pass0, cfg);

    work.b   = b;
    work.p1  = pass1;
    work.u   = u;
    work.q   = q;
    work.bx0 = drl_pkg::box_rgb(box_cur, u, cfg);
    work.bx1 = drl_pkg::box_rgb(box_below, q, cfg);
    if (!have_pending) begin
      work.kind = drl_pkg::KIND_PASS;
    end else if (item.line_last) begin
      work.kind = drl_pkg::KIND_FLUSH;
    end else begin
      work.kind = drl_pkg::KIND_FILTER;
    end
    // first pixel of a longer line only primes the window
    work_push = accept && (have_pending || item.line_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_pending <= 1'b0;
    end else if (accept) begin
      have_pending <= !item.line_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !item.line_last) begin
      lifted_window <= l;
      pass0         <= have_pending ? a : u;
      pass1         <= have_pending ? b : l;
      box_cur       <= u;
      box_below     <= q;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/drl_back.sv @@
// ----------------------------------------------------------------------------
// drl_back
// finishes the filter passes for a queued request and emits one or two
// results, one per cycle while the result queue has room
// ----------------------------------------------------------------------------
`default_nettype none

module drl_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire drl_pkg::cfg_t  cfg,
  input  wire logic           work_empty,
  input  wire drl_pkg::work_t work,
  output logic                work_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output drl_pkg::out_item_t  res
);

  logic            s1_valid;
  logic            s1_second;
  drl_pkg::kind_t  s1_kind;
  drl_pkg::rgb_t   s1_p1;
  drl_pkg::rgb_t   s1_c;
  drl_pkg::rgb_t   s1_bx0;
  drl_pkg::rgb_t   s1_bx1;
  drl_pkg::rgb_t   s1_u;
  drl_pkg::rgb_t   s1_r1;

  logic            emit;
  logic            done;
  logic            load;
  drl_pkg::rgb_t   r0;
  drl_pkg::rgb_t   r;

  always_comb begin
    emit     = s1_valid && !res_full;
    done     = emit && ((s1_kind != drl_pkg::KIND_FLUSH) || s1_second);
    load     = (!s1_valid || done) && !work_empty;
    work_pop = load;

    unique case (s1_kind)
      drl_pkg::KIND_PASS: r0 = s1_u;
      drl_pkg::KIND_FILTER,
      drl_pkg::KIND_FLUSH: begin
        if (cfg.filter_mode == drl_pkg::MODE_4X1) begin
          r0 = drl_pkg::blend_rgb(s1_p1, s1_c, cfg);
        end else begin
          r0 = drl_pkg::blend_rgb(s1_bx0, s1_bx1, cfg);
        end
      end
      default: r0 = s1_u;
    endcase

    r             = s1_second ? s1_r1 : r0;
    res_push      = emit;
    res.blue_out  = r[drl_pkg::BLUE_CH];
    res.green_out = r[drl_pkg::GREEN_CH];
    res.red_out   = r[drl_pkg::RED_CH];
    res.out_last  = s1_second || (s1_kind == drl_pkg::KIND_PASS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_second <= 1'b0;
    end else if (load) begin
      s1_valid  <= 1'b1;
      s1_second <= 1'b0;
    end else if (done) begin
      s1_valid  <= 1'b0;
      s1_second <= 1'b0;
    end else if (emit) begin
      s1_second <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_kind <= work.kind;
      s1_p1   <= work.p1;
      s1_c    <= drl_pkg::blend_rgb(work.b, work.p1, cfg);
      s1_bx0  <= work.bx0;
      s1_bx1  <= work.bx1;
      s1_u    <= work.u;
      s1_r1   <= (cfg.filter_mode == drl_pkg::MODE_4X1) ?
                 drl_pkg::blend_rgb(work.b, work.u, cfg) :
                 drl_pkg::blend_rgb(work.u, work.q, cfg);
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_dither_removal_line_filter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dither_removal_line_filter_unit
// drives rgb565 scanlines through the dither removal filter in both modes,
// predicts every filtered pixel in step with the requests that go in and
// compares each popped result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_dither_removal_line_filter_unit;
  import drl_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 8;     // back stage may still work on a held pixel
  localparam int TAIL_CYCLES   = 20;
  localparam int LONG_HOLD     = 100;   // receiver hold-off, long enough to fill the block
  localparam int STALL_LIMIT   = 2000;
  localparam logic [7:0] LIFT  = 8'd4;

  logic      clk = 1'b0;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;
  logic      wr_en;
  logic [1:0] wr_index;
  logic [7:0] wr_data;

  // predictor copy of the registers
  mode_t      cur_mode;
  logic [7:0] rb_thr;
  logic [7:0] g_thr;

  // predictor copy of the line window: the left neighbour and its pass values
  rgb_t left_lifted;
  rgb_t left_first;
  rgb_t left_second;
  rgb_t left_cur;
  rgb_t left_below;
  bit   mid_line;

  out_item_t filtered_due[$];   // filtered pixels still to come out, oldest first

  int mismatches  = 0;
  int idle_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;

  dither_removal_line_filter_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // filter prediction
  // ------------------------------------------------------------------------

  // 565 to 888 by plain shifts, no bit replication
  function automatic rgb_t unpack565(input logic [15:0] p);
    rgb_t v;
    v[BLUE_CH]  = {p[4:0], 3'b000};
    v[GREEN_CH] = {p[10:5], 2'b00};
    v[RED_CH]   = {p[15:11], 3'b000};
    return v;
  endfunction

  // pull g halfway toward h, a fall clamped to the threshold, rounded down;
  // a rise of at least the threshold leaves g alone
  function automatic logic [7:0] soften(input logic [7:0] g, input logic [7:0] h,
                                        input logic [7:0] t);
    int d;
    d = int'(h) - int'(g);
    if (d >= int'(t)) begin
      return g;
    end
    if (d < -int'(t)) begin
      d = -int'(t);
    end
    return 8'((2 * int'(g) + d) >>> 1);
  endfunction

  // take h only when it sits a little above g
  function automatic logic [7:0] snap_up(input logic [7:0] g, input logic [7:0] h,
                                         input logic [7:0] t);
    return ((h > g) && (h - g <= t)) ? h : g;
  endfunction

  function automatic out_item_t to_result(input rgb_t v, input logic last);
    out_item_t o;
    o.blue_out  = v[BLUE_CH];
    o.green_out = v[GREEN_CH];
    o.red_out   = v[RED_CH];
    o.out_last  = last;
    return o;
  endfunction

  function automatic void filter_pixel(input in_item_t it);
    rgb_t       u, q, l, a, b, c, r, f;
    logic [7:0] t;
    int         ch;
    u = unpack565(it.pixel);
    q = unpack565(it.below_pixel);
    // even rows raise red and blue, saturating
    l = u;
    for (ch = 0; ch < CHANNELS; ch++) begin
      if (it.even_row && ch != GREEN_CH) begin
        l[ch] = (u[ch] > CHAN_MAX - LIFT) ? CHAN_MAX : u[ch] + LIFT;
      end
    end
    if (!mid_line) begin
      // one-pixel line goes out unfiltered and unlifted
      if (it.line_last) begin
        filtered_due.push_back(to_result(u, 1'b1));
        return;
      end
      // line start: first pass holds the plain pixel, second the lifted one
      left_lifted = l;
      left_first  = u;
      left_second = l;
      left_cur    = u;
      left_below  = q;
      mid_line    = 1'b1;
      return;
    end
    for (ch = 0; ch < CHANNELS; ch++) begin
      t = (ch == GREEN_CH) ? g_thr : rb_thr;
      a[ch] = soften(l[ch], left_lifted[ch], t);
      b[ch] = soften(l[ch], left_first[ch], t);
      c[ch] = soften(b[ch], left_second[ch], t);
      if (cur_mode == MODE_4X1) begin
        r[ch] = soften(left_second[ch], c[ch], t);
        // right edge: own unlifted value stands in for the right neighbour
        f[ch] = soften(b[ch], u[ch], t);
      end else begin
        r[ch] = soften(snap_up(left_cur[ch], u[ch], t), snap_up(left_below[ch], q[ch], t), t);
        f[ch] = soften(u[ch], q[ch], t);
      end
    end
    filtered_due.push_back(to_result(r, 1'b0));
    if (it.line_last) begin
      // last pixel flushes itself as well
      filtered_due.push_back(to_result(f, 1'b1));
      mid_line = 1'b0;
    end else begin
      left_lifted = l;
      left_first  = a;
      left_second = b;
      left_cur    = u;
      left_below  = q;
    end
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // neighbouring pixel a few codes away so the thresholds actually matter
  function automatic logic [15:0] nudge565(input logic [15:0] p);
    int r, g, b;
    r = int'(p[15:11]) + int'($urandom_range(0, 4)) - 2;
    g = int'(p[10:5]) + int'($urandom_range(0, 6)) - 3;
    b = int'(p[4:0]) + int'($urandom_range(0, 4)) - 2;
    r = (r < 0) ? 0 : ((r > 31) ? 31 : r);
    g = (g < 0) ? 0 : ((g > 63) ? 63 : g);
    b = (b < 0) ? 0 : ((b > 31) ? 31 : b);
    return {5'(r), 6'(g), 5'(b)};
  endfunction

  function automatic logic [7:0] pick_threshold();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 12));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly short lines, now and then a long one
  function automatic int pick_length();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 40))
                                       : int'($urandom_range(1, 8));
  endfunction

  // one pixel request, held until the block takes it
  task automatic send_pixel(input logic [15:0] pix, input logic [15:0] below,
                            input logic even, input logic last);
    in_item_t it;
    it.pixel       = pix;
    it.below_pixel = below;
    it.even_row    = even;
    it.line_last   = last;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    filter_pixel(it);
  endtask

  task automatic park_sender();
    @(negedge clk);
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (filtered_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_FILTER_MODE:  cur_mode = mode_t'(data[0]);
      REG_RB_THRESHOLD: rb_thr = data;
      REG_G_THRESHOLD:  g_thr = data;
      default: ;
    endcase
  endtask

  // registers only change with the block idle, so wait out every result first
  task automatic apply_config(input mode_t mode, input logic [7:0] rb, input logic [7:0] g);
    park_sender();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // unused upper bits of the mode write carry noise
    write_reg(REG_FILTER_MODE, {7'($urandom_range(0, 127)), mode});
    write_reg(REG_RB_THRESHOLD, rb);
    write_reg(REG_G_THRESHOLD, g);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic random_config();
    apply_config(mode_t'($urandom_range(0, 1)), pick_threshold(), pick_threshold());
  endtask

  // one scanline with smooth content, stray jumps and occasional parity flips
  task automatic send_line(input int len, input bit may_reconfig);
    logic [15:0] pix;
    logic [15:0] below;
    logic        even;
    int          k;
    even = 1'($urandom_range(0, 1));
    pix  = 16'($urandom);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        even = ~even;
      end
      if (k != 0 && $urandom_range(0, 3) != 0) begin
        pix = nudge565(pix);
      end else begin
        pix = 16'($urandom);
      end
      case ($urandom_range(0, 3))
        0:       below = pix;            // last display line
        1:       below = 16'($urandom);
        default: below = nudge565(pix);
      endcase
      if (may_reconfig && k != 0 && $urandom_range(0, 59) == 0) begin
        random_config();
      end
      send_pixel(pix, below, even, k == len - 1);
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  task automatic test_one_pixel_lines();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_config(MODE_4X1, 8'd0, 8'd0);
    send_pixel(16'hFFFF, 16'h0000, 1'b1, 1'b1);
    send_pixel(16'h0000, 16'hFFFF, 1'b0, 1'b1);
    apply_config(MODE_2X2, 8'd255, 8'd255);
    send_pixel(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_pixel(16'hF81F, 16'h07E0, 1'b0, 1'b1);
  endtask

  // two and three pixel lines: line start and right edge in both modes
  task automatic test_line_edges();
    apply_config(MODE_4X1, 8'd255, 8'd255);
    send_pixel(16'hF800, 16'h07E0, 1'b1, 1'b0);
    send_pixel(16'h001F, 16'hFFFF, 1'b1, 1'b1);
    send_pixel(16'h8410, 16'h8430, 1'b0, 1'b0);
    send_pixel(16'h8C51, 16'h7BEF, 1'b0, 1'b0);
    send_pixel(16'h7BEF, 16'h7BEF, 1'b0, 1'b1);
    apply_config(MODE_2X2, 8'd16, 8'd8);
    send_pixel(16'h8410, 16'h8C51, 1'b1, 1'b0);
    send_pixel(16'h8C71, 16'h8410, 1'b1, 1'b0);
    send_pixel(16'h0000, 16'hFFFF, 1'b1, 1'b1);
    send_pixel(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_pixel(16'hFFDF, 16'hFFFF, 1'b0, 1'b1);
  endtask

  // parity, mode and thresholds change while a line is open
  task automatic test_mid_line_changes();
    apply_config(MODE_4X1, 8'd40, 8'd20);
    send_pixel(16'h4208, 16'h4A49, 1'b1, 1'b0);
    send_pixel(16'h528A, 16'h4208, 1'b0, 1'b0);
    apply_config(MODE_2X2, 8'd40, 8'd20);
    send_pixel(16'h4A69, 16'h5ACB, 1'b0, 1'b0);
    apply_config(MODE_2X2, 8'd3, 8'd200);
    send_pixel(16'h39E7, 16'h4208, 1'b1, 1'b0);
    apply_config(MODE_4X1, 8'd3, 8'd200);
    send_pixel(16'h3186, 16'h39E7, 1'b0, 1'b1);
  endtask

  task automatic test_random_lines(input int n_items, input int tx_pct, input int rx_pct);
    int left;
    int len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    random_config();
    left = n_items;
    while (left > 0) begin
      len = pick_length();
      send_line(len, 1'b1);
      left -= len;
      if ($urandom_range(0, 7) == 0) begin
        random_config();
      end
    end
  endtask

  // receiver holds off while requests keep coming, then the sender
  // pauses in the middle of a line until everything is out
  task automatic test_stall_and_drain();
    int sent_here;
    int len;
    tx_idle_pct = 0;
    rx_idle_pct = 50;
    apply_config(MODE_4X1, 8'd24, 8'd12);
    hold_req  = 1'b1;
    sent_here = 0;
    while (sent_here < 40) begin
      len = pick_length();
      send_line(len, 1'b0);
      sent_here += len;
    end
    send_pixel(16'h1234, 16'h1254, 1'b1, 1'b0);
    send_pixel(16'h1254, 16'h1234, 1'b1, 1'b0);
    send_pixel(16'h1A75, 16'h1254, 1'b1, 1'b0);
    park_sender();
    wait_drained();
    send_pixel(16'h1A55, 16'h1A75, 1'b1, 1'b0);
    send_pixel(16'h2296, 16'h2296, 1'b1, 1'b1);
  endtask

  // ------------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------------

  // pop at random; a hold request parks it for a long stretch
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (filtered_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %p", $time, out_item);
      end else begin
        want = filtered_due.pop_front();
        check_field("blue_out", want.blue_out, out_item.blue_out);
        check_field("green_out", want.green_out, out_item.green_out);
        check_field("red_out", want.red_out, out_item.red_out);
        check_field("out_last", want.out_last, out_item.out_last);
      end
    end
  end

  // ends the run when no request moves on either side for too long
  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles, %0d results outstanding",
               $time, idle_cycles, filtered_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // run
  // ------------------------------------------------------------------------
  initial begin : run
    rst         = 1'b1;
    push        = 1'b0;
    in_item     = '0;
    wr_en       = 1'b0;
    wr_index    = REG_FILTER_MODE;
    wr_data     = '0;
    cur_mode    = MODE_4X1;
    rb_thr      = '0;
    g_thr       = '0;
    left_lifted = '0;
    left_first  = '0;
    left_second = '0;
    left_cur    = '0;
    left_below  = '0;
    mid_line    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_one_pixel_lines();
    test_line_edges();
    test_mid_line_changes();
    test_random_lines(370, 27, 81);
    test_random_lines(370, 81, 27);
    test_stall_and_drain();
    test_random_lines(370, 0, 0);

    park_sender();
    wait_drained();
    // anything arriving now is an extra result
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && filtered_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
